>>> sv/stereo_crosstalk_canceller_macros.svh
// Assertion shorthands shared by the canceller RTL.
`ifndef STEREO_CROSSTALK_CANCELLER_MACROS_SVH
`define STEREO_CROSSTALK_CANCELLER_MACROS_SVH

// Same-cycle implication, checked out of reset only.
`define SXC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sxc: same-cycle check failed");

// Next-cycle implication, checked out of reset only.
`define SXC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sxc: next-cycle check failed");

`endif

>>> sv/sxc_pkg.sv
`timescale 1ns / 1ps
package sxc_pkg;

  // Fixed sample and line widths
  localparam int unsigned SAMPLE_BITS   = 24;
  localparam int unsigned LINE_BITS     = SAMPLE_BITS + 2;
  localparam int unsigned MAX_DELAY_DEF = 1024;

  // Gain formats
  localparam int unsigned GAIN_W  = 20;
  localparam int unsigned DECAY_W = 17;
  localparam int unsigned DELAY_W = 11;
  localparam int unsigned FRAC_W  = 16;
  localparam logic [DECAY_W-1:0] DECAY_UNITY = DECAY_W'(65536);

  // Multiplier lane and accumulator widths
  localparam int unsigned PROD_W = LINE_BITS + GAIN_W + 1;
  localparam int unsigned RND_W  = PROD_W - FRAC_W;
  localparam int unsigned ACC_W  = 32;
  localparam int unsigned MIX_W  = LINE_BITS + 1;

  // Configuration port
  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = 3;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [LINE_BITS-1:0]   line_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [ACC_W-1:0]       acc_t;
  typedef logic [GAIN_W-1:0]             gain_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_BYPASS   = 3'd0,
    REG_CENTRE   = 3'd1,
    REG_DELAY    = 3'd2,
    REG_DECAY    = 3'd3,
    REG_GAIN_IN  = 3'd4,
    REG_GAIN_OUT = 3'd5
  } sxc_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GAIN_IN,
    ST_FEEDBACK,
    ST_CANCEL,
    ST_MIX,
    ST_GAIN_OUT,
    ST_DONE
  } sxc_state_t;

  // Q16 product rounded to nearest, ties upward
  function automatic logic signed [RND_W-1:0] round_q16(input prod_t p);
    prod_t s;
    s = p + PROD_W'(32768);
    return s[PROD_W-1:FRAC_W];
  endfunction

  function automatic acc_t rnd_ext(input prod_t p);
    return ACC_W'(round_q16(p));
  endfunction

  function automatic sample_t sat_sample(input acc_t v);
    acc_t hi;
    acc_t lo;
    hi = ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    lo = -hi - ACC_W'(1);
    if (v > hi) return sample_t'(hi);
    if (v < lo) return sample_t'(lo);
    return v[SAMPLE_BITS-1:0];
  endfunction

  function automatic line_t sat_line(input acc_t v);
    acc_t hi;
    acc_t lo;
    hi = ACC_W'((64'sd1 <<< (LINE_BITS - 1)) - 64'sd1);
    lo = -hi - ACC_W'(1);
    if (v > hi) return line_t'(hi);
    if (v < lo) return line_t'(lo);
    return v[LINE_BITS-1:0];
  endfunction

endpackage

>>> sv/sxc_in_if.sv
`timescale 1ns / 1ps
interface sxc_in_if;
  import sxc_pkg::*;

  logic    valid;
  logic    ready;
  sample_t left_sample;
  sample_t right_sample;

  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink (input valid, input left_sample, input right_sample, output ready);
endinterface

>>> sv/sxc_out_if.sv
`timescale 1ns / 1ps
interface sxc_out_if;
  import sxc_pkg::*;

  logic    valid;
  logic    ready;
  sample_t left_result;
  sample_t right_result;

  modport source (output valid, output left_result, output right_result, input ready);
  modport sink (input valid, input left_result, input right_result, output ready);
endinterface

>>> sv/sxc_ram.sv
`timescale 1ns / 1ps
module sxc_ram #(
  parameter int unsigned WIDTH = 26,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write one entry, register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

>>> sv/stereo_crosstalk_canceller.sv
`timescale 1ns / 1ps
// Channel   | Dir | Payload                          | Handshake
// in_chan   | in  | left_sample, right_sample (Q1.23) | valid / ready
// out_chan  | out | left_result, right_result (Q1.23) | valid / ready
// cfg (APB) | in  | psel..pwdata, prdata, pready      | write on access phase
//
// Between acceptance and the next acceptance of a processed frame, the
// sequencer walks input gain, feedback, cancel, mix and output gain over two
// multiplier lanes, after a registered read of the feedback line RAMs.
// A bypassed frame skips these steps and goes straight to the output register.
// After reset both line RAMs are zeroed by a clearing pass over every entry,
// during which no frame is accepted; configuration writes are taken throughout.
// A stalled result waits in the output register; the engine holds in its last
// step until that register is free.
`include "stereo_crosstalk_canceller_macros.svh"
module stereo_crosstalk_canceller #(
  parameter int unsigned MAX_DELAY = sxc_pkg::MAX_DELAY_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  sxc_in_if.sink                            in_chan,
  sxc_out_if.source                         out_chan,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sxc_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [sxc_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [sxc_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import sxc_pkg::*;

  localparam int unsigned PTR_W = $clog2(MAX_DELAY);
  localparam int unsigned DLY_W = $clog2(MAX_DELAY + 1);
  localparam int unsigned SUM_W = DLY_W + 1;

  // ------------------------------------------------------------------
  // Configuration registers
  // ------------------------------------------------------------------
  logic               bypass_r;
  logic               centre_r;
  logic [DELAY_W-1:0] delay_r;
  logic [DECAY_W-1:0] decay_r;
  gain_t              gain_in_r;
  gain_t              gain_out_r;
  logic               cfg_wr;
  sxc_reg_t           reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_idx = sxc_reg_t'(paddr[CFG_ADDR_W-1:2]);

  // Take a register write on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bypass_r   <= 1'b0;
      centre_r   <= 1'b0;
      delay_r    <= DELAY_W'(1);
      decay_r    <= DECAY_W'(32768);
      gain_in_r  <= GAIN_W'(65536);
      gain_out_r <= GAIN_W'(65536);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_BYPASS:   bypass_r   <= pwdata[0];
        REG_CENTRE:   centre_r   <= pwdata[0];
        REG_DELAY:    delay_r    <= pwdata[DELAY_W-1:0];
        REG_DECAY:    decay_r    <= pwdata[DECAY_W-1:0];
        REG_GAIN_IN:  gain_in_r  <= pwdata[GAIN_W-1:0];
        REG_GAIN_OUT: gain_out_r <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back a register
  always_comb begin
    unique case (reg_idx)
      REG_BYPASS:   prdata = CFG_DATA_W'(bypass_r);
      REG_CENTRE:   prdata = CFG_DATA_W'(centre_r);
      REG_DELAY:    prdata = CFG_DATA_W'(delay_r);
      REG_DECAY:    prdata = CFG_DATA_W'(decay_r);
      REG_GAIN_IN:  prdata = CFG_DATA_W'(gain_in_r);
      REG_GAIN_OUT: prdata = CFG_DATA_W'(gain_out_r);
      default:      prdata = '0;
    endcase
  end

  // ------------------------------------------------------------------
  // Clamped delay and decay, read address
  // ------------------------------------------------------------------
  logic [DLY_W-1:0]   delay_eff;
  logic [DECAY_W-1:0] decay_eff;
  logic [SUM_W-1:0]   rd_sum;
  logic [PTR_W-1:0]   rd_addr;
  logic [PTR_W-1:0]   wp_r;
  logic [PTR_W-1:0]   wp_nxt;

  always_comb begin
    priority if (delay_r == '0) begin
      delay_eff = DLY_W'(1);
    end else if (32'(delay_r) > 32'(MAX_DELAY)) begin
      delay_eff = DLY_W'(MAX_DELAY);
    end else begin
      delay_eff = DLY_W'(delay_r);
    end
  end

  assign decay_eff = (decay_r > DECAY_UNITY) ? DECAY_UNITY : decay_r;

  // Ring index of the entry written delay frames ago
  always_comb begin
    rd_sum = SUM_W'(wp_r) + SUM_W'(MAX_DELAY) - SUM_W'(delay_eff);
    if (rd_sum >= SUM_W'(MAX_DELAY)) begin
      rd_sum = rd_sum - SUM_W'(MAX_DELAY);
    end
  end

  assign rd_addr = rd_sum[PTR_W-1:0];
  assign wp_nxt  = (wp_r == PTR_W'(MAX_DELAY - 1)) ? '0 : wp_r + 1'b1;

  // ------------------------------------------------------------------
  // Sequencer
  // ------------------------------------------------------------------
  sxc_state_t state_r;
  sxc_state_t state_nxt;
  logic       clear_r;
  logic [PTR_W-1:0] clear_cnt_r;
  logic       in_beat;
  logic       out_load;
  logic       out_valid_r;
  logic       eng_ready;
  logic       ram_re;
  logic       line_we;
  logic       right_we;

  assign in_beat  = in_chan.valid & in_chan.ready;
  assign out_load = (state_r == ST_DONE) & (~out_valid_r | out_chan.ready);

  // Next step of the frame
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          state_nxt = bypass_r ? ST_DONE : ST_GAIN_IN;
        end
      end
      ST_GAIN_IN:  state_nxt = ST_FEEDBACK;
      ST_FEEDBACK: state_nxt = ST_CANCEL;
      ST_CANCEL:   state_nxt = ST_MIX;
      ST_MIX:      state_nxt = ST_GAIN_OUT;
      ST_GAIN_OUT: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Strobes for each step
  always_comb begin
    eng_ready = 1'b0;
    ram_re    = 1'b0;
    line_we   = 1'b0;
    right_we  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        eng_ready = ~clear_r;
        ram_re    = in_chan.valid & ~clear_r;
      end
      ST_CANCEL: begin
        line_we  = 1'b1;
        right_we = ~centre_r;
      end
      default: ;
    endcase
  end

  assign in_chan.ready = eng_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      clear_r     <= 1'b1;
      clear_cnt_r <= '0;
      wp_r        <= '0;
    end else begin
      state_r <= state_nxt;
      // Sweep zeros through both lines after reset
      if (clear_r) begin
        clear_cnt_r <= clear_cnt_r + 1'b1;
        if (clear_cnt_r == PTR_W'(MAX_DELAY - 1)) begin
          clear_r <= 1'b0;
        end
      end
      // Advance the ring pointer once per processed frame
      if (line_we) begin
        wp_r <= wp_nxt;
      end
    end
  end

  // ------------------------------------------------------------------
  // Feedback line RAMs
  // ------------------------------------------------------------------
  line_t            fb_left;
  line_t            fb_right;
  line_t            cancel_l;
  line_t            cancel_r;
  logic [PTR_W-1:0] ram_waddr;
  line_t            ram_wdata_l;
  line_t            ram_wdata_r;

  assign ram_waddr   = clear_r ? clear_cnt_r : wp_r;
  assign ram_wdata_l = clear_r ? '0 : cancel_l;
  assign ram_wdata_r = clear_r ? '0 : cancel_r;

  sxc_ram #(
    .WIDTH (LINE_BITS),
    .DEPTH (MAX_DELAY)
  ) u_left_line (
    .clk   (clk),
    .we    (clear_r | line_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata_l),
    .re    (ram_re),
    .raddr (rd_addr),
    .rdata (fb_left)
  );

  sxc_ram #(
    .WIDTH (LINE_BITS),
    .DEPTH (MAX_DELAY)
  ) u_right_line (
    .clk   (clk),
    .we    (clear_r | right_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata_r),
    .re    (ram_re),
    .raddr (rd_addr),
    .rdata (fb_right)
  );

  // ------------------------------------------------------------------
  // Datapath: two multiplier lanes and the step registers
  // ------------------------------------------------------------------
  sample_t in_l_r;
  sample_t in_r_r;
  sample_t gl_r;
  sample_t gr_r;
  line_t   cl_r;
  line_t   cr_r;
  line_t   lo_r;
  line_t   ro_r;
  prod_t   prod_a_r;
  prod_t   prod_b_r;
  line_t   mul_a;
  line_t   mul_b;
  gain_t   mul_gain;
  acc_t    mid_ext;
  logic signed [MIX_W-1:0] side;
  logic signed [MIX_W-1:0] mix_l;
  logic signed [MIX_W-1:0] mix_r;
  sample_t res_l;
  sample_t res_r;

  // Pick lane operands for the current step
  always_comb begin
    unique case (state_r)
      ST_FEEDBACK: begin
        mul_a    = centre_r ? fb_left : fb_right;
        mul_b    = fb_left;
        mul_gain = GAIN_W'(decay_eff);
      end
      ST_GAIN_OUT: begin
        mul_a    = lo_r;
        mul_b    = ro_r;
        mul_gain = gain_out_r;
      end
      default: begin
        mul_a    = LINE_BITS'(in_l_r);
        mul_b    = LINE_BITS'(in_r_r);
        mul_gain = gain_in_r;
      end
    endcase
  end

  // Cancel against the rounded feedback products
  always_comb begin
    mid_ext  = ACC_W'(gl_r) + ACC_W'(gr_r);
    cancel_l = centre_r ? sat_line(mid_ext - rnd_ext(prod_a_r))
                        : sat_line(ACC_W'(gl_r) - rnd_ext(prod_a_r));
    cancel_r = sat_line(ACC_W'(gr_r) - rnd_ext(prod_b_r));
  end

  // Recombine mid and side in centre mode, halving with floor
  always_comb begin
    side  = MIX_W'(gl_r) - MIX_W'(gr_r);
    mix_l = (MIX_W'(cl_r) + side) >>> 1;
    mix_r = (MIX_W'(cl_r) - side) >>> 1;
  end

  assign res_l = bypass_r ? in_l_r : sat_sample(rnd_ext(prod_a_r));
  assign res_r = bypass_r ? in_r_r : sat_sample(rnd_ext(prod_b_r));

  always_ff @(posedge clk) begin
    // Hold the output-gain products while the result waits
    if (state_r != ST_DONE) begin
      prod_a_r <= mul_a * $signed({1'b0, mul_gain});
      prod_b_r <= mul_b * $signed({1'b0, mul_gain});
    end
    if (in_beat) begin
      in_l_r <= in_chan.left_sample;
      in_r_r <= in_chan.right_sample;
    end
    if (state_r == ST_FEEDBACK) begin
      gl_r <= sat_sample(rnd_ext(prod_a_r));
      gr_r <= sat_sample(rnd_ext(prod_b_r));
    end
    if (state_r == ST_CANCEL) begin
      cl_r <= cancel_l;
      cr_r <= cancel_r;
    end
    if (state_r == ST_MIX) begin
      lo_r <= centre_r ? mix_l[LINE_BITS-1:0] : cl_r;
      ro_r <= centre_r ? mix_r[LINE_BITS-1:0] : cr_r;
    end
  end

  // ------------------------------------------------------------------
  // Output register
  // ------------------------------------------------------------------
  sample_t out_l_r;
  sample_t out_r_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Hold the result beat until taken
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_l_r <= res_l;
      out_r_r <= res_r;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.left_result  = out_l_r;
  assign out_chan.right_result = out_r_r;

  // ------------------------------------------------------------------
  // Checks
  // ------------------------------------------------------------------
  `SXC_ASSERT_IMP(a_no_beat_in_clear, clk, rst_n, clear_r, !in_chan.ready)
  `SXC_ASSERT_NXT(a_out_hold, clk, rst_n, out_chan.valid && !out_chan.ready, out_chan.valid)
  `SXC_ASSERT_NXT(a_beat_starts_frame, clk, rst_n, in_beat, state_r != ST_IDLE)
  `SXC_ASSERT_IMP(a_result_from_done, clk, rst_n, $rose(out_valid_r), $past(state_r == ST_DONE))

endmodule

>>> tb/stereo_crosstalk_canceller_checker.sv
`timescale 1ns / 1ps
module stereo_crosstalk_canceller_checker
  import sxc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  sxc_in_if                     in_mon,
  sxc_out_if                    out_mon,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output int unsigned           mismatch_count,
  output int unsigned           frames_pending
);

  localparam longint LINE_DEPTH = MAX_DELAY_DEF;
  localparam longint UNITY_GAIN = 65536;
  localparam int unsigned PRINT_CAP = 100;

  typedef struct {
    sample_t left;
    sample_t right;
  } frame_t;

  // Shadow copy of the register file
  logic               bypass_on;
  logic               centre_on;
  logic [DELAY_W-1:0] delay_reg;
  logic [DECAY_W-1:0] decay_reg;
  gain_t              gain_in_reg;
  gain_t              gain_out_reg;

  // Shadow copy of the feedback lines
  line_t              left_line [LINE_DEPTH];
  line_t              right_line [LINE_DEPTH];
  int unsigned        write_idx;

  frame_t             expected_frames [$];
  int unsigned        fail_total;

  function automatic longint q16_scale(input longint x, input longint g);
    return (x * g + 32768) >>> 16;
  endfunction

  function automatic longint saturate_to(input longint v, input int unsigned bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Work out one output frame; unless bypassed, also update the shadow lines and index
  function automatic frame_t cancel_frame(input sample_t l_in, input sample_t r_in);
    frame_t res;
    longint l;
    longint r;
    longint lo;
    longint ro;
    longint mo;
    longint dly;
    longint dec;
    longint rd;
    if (bypass_on) begin
      res.left  = l_in;
      res.right = r_in;
      return res;
    end
    l = saturate_to(q16_scale(l_in, gain_in_reg), SAMPLE_BITS);
    r = saturate_to(q16_scale(r_in, gain_in_reg), SAMPLE_BITS);
    dly = delay_reg;
    if (dly < 1) dly = 1;
    if (dly > LINE_DEPTH) dly = LINE_DEPTH;
    dec = decay_reg;
    if (dec > UNITY_GAIN) dec = UNITY_GAIN;
    rd = (longint'(write_idx) + LINE_DEPTH - dly) % LINE_DEPTH;
    if (centre_on) begin
      // cancel the mid signal only, then split back with the side signal
      mo = saturate_to((l + r) - q16_scale(left_line[rd], dec), LINE_BITS);
      lo = (mo + (l - r)) >>> 1;
      ro = (mo - (l - r)) >>> 1;
      left_line[write_idx] = line_t'(mo);
    end else begin
      lo = saturate_to(l - q16_scale(right_line[rd], dec), LINE_BITS);
      ro = saturate_to(r - q16_scale(left_line[rd], dec), LINE_BITS);
      left_line[write_idx]  = line_t'(lo);
      right_line[write_idx] = line_t'(ro);
    end
    write_idx = (write_idx + 1) % MAX_DELAY_DEF;
    res.left  = sample_t'(saturate_to(q16_scale(lo, gain_out_reg), SAMPLE_BITS));
    res.right = sample_t'(saturate_to(q16_scale(ro, gain_out_reg), SAMPLE_BITS));
    return res;
  endfunction

  task automatic report_mismatch(input string note);
    fail_total++;
    // keep the log short on a badly broken build
    if (fail_total <= PRINT_CAP) $display("%0t: %s", $time, note);
  endtask

  always @(posedge clk) begin
    frame_t want;
    frame_t got;
    if (!rst_n) begin
      bypass_on    = 1'b0;
      centre_on    = 1'b0;
      delay_reg    = DELAY_W'(1);
      decay_reg    = DECAY_W'(32768);
      gain_in_reg  = gain_t'(65536);
      gain_out_reg = gain_t'(65536);
      for (int i = 0; i < LINE_DEPTH; i++) begin
        left_line[i]  = '0;
        right_line[i] = '0;
      end
      write_idx = 0;
      expected_frames.delete();
    end else begin
      // Track register writes on the access phase
      if (psel && penable && pwrite && pready) begin
        case (sxc_reg_t'(paddr[CFG_ADDR_W-1:2]))
          REG_BYPASS:   bypass_on    = pwdata[0];
          REG_CENTRE:   centre_on    = pwdata[0];
          REG_DELAY:    delay_reg    = pwdata[DELAY_W-1:0];
          REG_DECAY:    decay_reg    = pwdata[DECAY_W-1:0];
          REG_GAIN_IN:  gain_in_reg  = pwdata[GAIN_W-1:0];
          REG_GAIN_OUT: gain_out_reg = pwdata[GAIN_W-1:0];
          default: ;
        endcase
      end
      // Check a result beat against the oldest expectation
      if (out_mon.valid && out_mon.ready) begin
        got.left  = out_mon.left_result;
        got.right = out_mon.right_result;
        if (expected_frames.size() == 0) begin
          report_mismatch($sformatf("result beat L=%0d R=%0d with nothing pending",
                                    got.left, got.right));
        end else begin
          want = expected_frames.pop_front();
          if (got.left !== want.left)
            report_mismatch($sformatf("left_result got %0d, want %0d", got.left, want.left));
          if (got.right !== want.right)
            report_mismatch($sformatf("right_result got %0d, want %0d",
                                      got.right, want.right));
        end
      end
      // Predict from an input beat
      if (in_mon.valid && in_mon.ready)
        expected_frames.push_back(cancel_frame(in_mon.left_sample, in_mon.right_sample));
    end
    mismatch_count = fail_total;
    frames_pending = expected_frames.size();
  end

endmodule

>>> tb/stereo_crosstalk_canceller_test.sv
`timescale 1ns / 1ps
module stereo_crosstalk_canceller_test;
  import sxc_pkg::*;

  localparam int unsigned STALL_LIMIT   = 5000;
  localparam int unsigned RANDOM_PHASES = 11;
  localparam int unsigned PHASE_ITEMS   = 130;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam sample_t     SAMPLE_MAX    = sample_t'(24'h7FFFFF);
  localparam sample_t     SAMPLE_MIN    = sample_t'(24'h800000);

  typedef struct {
    logic               bypass;
    logic               centre;
    logic [DELAY_W-1:0] delay;
    logic [DECAY_W-1:0] decay;
    gain_t              gain_in;
    gain_t              gain_out;
  } setup_t;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic                  pready;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;

  int unsigned send_idle_pct = 37;
  int unsigned recv_idle_pct = 86;
  logic        long_hold_req = 1'b0;
  logic        long_hold_done;
  int unsigned hold_left;
  int unsigned quiet_cycles;
  int unsigned mismatch_count;
  int unsigned frames_pending;

  sxc_in_if  in_chan ();
  sxc_out_if out_chan ();

  stereo_crosstalk_canceller DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  stereo_crosstalk_canceller_checker frame_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_chan),
    .out_mon        (out_chan),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .mismatch_count (mismatch_count),
    .frames_pending (frames_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    out_chan.ready <= 1'b0;
    hold_left = 0;
    long_hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req && !long_hold_done) begin
        hold_left = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_chan.ready <= 1'b0;
        hold_left--;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // End the run when nothing moves for too long
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
          (psel && penable)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("stereo_crosstalk_canceller test failed");
    $finish;
  end

  // Offer one frame, idling at random first; valid stays high on return
  task automatic send_frame(input sample_t l, input sample_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.left_sample  <= l;
    in_chan.right_sample <= r;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  // Drop valid and hold until every expected frame has come back
  task automatic drain();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (frames_pending != 0);
  endtask

  // Setup and access cycles; psel stays high for a following write
  task automatic write_reg(input sxc_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic apply_setup(input setup_t s);
    write_reg(REG_BYPASS, CFG_DATA_W'(s.bypass));
    write_reg(REG_CENTRE, CFG_DATA_W'(s.centre));
    write_reg(REG_DELAY, CFG_DATA_W'(s.delay));
    write_reg(REG_DECAY, CFG_DATA_W'(s.decay));
    write_reg(REG_GAIN_IN, CFG_DATA_W'(s.gain_in));
    write_reg(REG_GAIN_OUT, CFG_DATA_W'(s.gain_out));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly full-range samples, with some small values and rails
  function automatic sample_t pick_sample();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: return SAMPLE_MAX;
          1: return SAMPLE_MIN;
          2: return '0;
          default: return '1;
        endcase
      end
      1, 2: return sample_t'(int'($urandom_range(8191)) - 4096);
      default: return sample_t'($urandom());
    endcase
  endfunction

  function automatic gain_t pick_gain();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return gain_t'($urandom());
      default: return gain_t'($urandom_range(81920, 49152));
    endcase
  endfunction

  // Short delays most of the time so the feedback path gets exercised
  function automatic setup_t pick_setup();
    setup_t s;
    s.bypass = ($urandom_range(5) == 0);
    s.centre = ($urandom_range(2) == 0);
    case ($urandom_range(9))
      0: s.delay = '0;
      1: s.delay = DELAY_W'(1024);
      2: s.delay = DELAY_W'($urandom_range(2047, 1025));
      3: s.delay = DELAY_W'(1023);
      default: s.delay = DELAY_W'($urandom_range(48, 1));
    endcase
    case ($urandom_range(9))
      0: s.decay = '0;
      1: s.decay = DECAY_UNITY;
      2: s.decay = DECAY_W'($urandom_range(131071, 65537));
      default: s.decay = DECAY_W'($urandom_range(65536, 0));
    endcase
    s.gain_in  = pick_gain();
    s.gain_out = pick_gain();
    return s;
  endfunction

  initial begin
    rst_n                <= 1'b0;
    in_chan.valid        <= 1'b0;
    in_chan.left_sample  <= '0;
    in_chan.right_sample <= '0;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: rails and sign edges
    send_frame('0, '0);
    send_frame(SAMPLE_MAX, SAMPLE_MIN);
    send_frame(SAMPLE_MIN, SAMPLE_MAX);
    send_frame('1, sample_t'(1));
    send_frame(SAMPLE_MAX, SAMPLE_MAX);
    send_frame(SAMPLE_MIN, SAMPLE_MIN);
    drain();

    // Zero delay acts as one, decay above unity clips, input gain saturates
    apply_setup('{1'b0, 1'b0, DELAY_W'(0), DECAY_W'(131071), gain_t'(1048575),
                  gain_t'(65536)});
    send_frame(SAMPLE_MAX, SAMPLE_MIN);
    send_frame(sample_t'(1000), sample_t'(-1000));
    send_frame('1, '0);
    drain();

    // Centre-only with delay beyond the line length and maximum output gain
    apply_setup('{1'b0, 1'b1, DELAY_W'(2047), DECAY_UNITY, gain_t'(65536),
                  gain_t'(1048575)});
    send_frame(SAMPLE_MAX, SAMPLE_MAX);
    send_frame(SAMPLE_MIN, SAMPLE_MAX);
    send_frame(sample_t'(12345), sample_t'(-54321));
    drain();

    // Bypass must leave the lines and the ring index alone
    apply_setup('{1'b1, 1'b1, DELAY_W'(2047), DECAY_UNITY, gain_t'(65536),
                  gain_t'(1048575)});
    send_frame(SAMPLE_MAX, SAMPLE_MIN);
    send_frame('0, '1);
    send_frame(pick_sample(), pick_sample());
    drain();

    // Delay change keeps old line contents; zero gains
    apply_setup('{1'b0, 1'b0, DELAY_W'(3), DECAY_UNITY, gain_t'(0), gain_t'(0)});
    send_frame(SAMPLE_MAX, SAMPLE_MIN);
    send_frame(sample_t'(-7), sample_t'(7));
    drain();

    // Centre-only at full gain to drive the mid line into saturation
    apply_setup('{1'b0, 1'b1, DELAY_W'(1), DECAY_W'(98304), gain_t'(1048575),
                  gain_t'(65536)});
    send_frame(SAMPLE_MAX, SAMPLE_MAX);
    send_frame(SAMPLE_MIN, SAMPLE_MIN);
    send_frame(SAMPLE_MAX, SAMPLE_MIN);
    send_frame(SAMPLE_MIN, SAMPLE_MAX);
    drain();

    // Random settings per phase, with the idling pattern changing over the run
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p < 4) begin
        send_idle_pct = 37;
        recv_idle_pct = 86;
      end else if (p < 8) begin
        send_idle_pct = 86;
        recv_idle_pct = 37;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      apply_setup(pick_setup());
      if (p == 8) long_hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 9 && n == PHASE_ITEMS / 2) drain();
        send_frame(pick_sample(), pick_sample());
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && frames_pending == 0) begin
      $display("stereo_crosstalk_canceller test passed");
    end else begin
      $display("stereo_crosstalk_canceller test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/sxc_pkg.sv
sv/sxc_in_if.sv
sv/sxc_out_if.sv
sv/sxc_ram.sv
sv/stereo_crosstalk_canceller.sv
tb/stereo_crosstalk_canceller_checker.sv
tb/stereo_crosstalk_canceller_test.sv
